// ===== rtl/core/m3inv_pkg.sv =====
// Shared types, codes and address helpers for the 3x3 matrix inverse and solve block.
// Used by m3inv_ctrl, m3inv_dp and the top level; depends on nothing.
package m3inv_pkg;

    // Default widths of the fixed-point format.
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Number of entries in the matrix store and in the cofactor store.
    localparam int MAT_N = 9;

    // Operation codes carried in the mode field of an input word.
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_DET   = 2'd1;
    localparam logic [1:0] MODE_INV   = 2'd2;
    localparam logic [1:0] MODE_SOLVE = 2'd3;

    // A load with this row select is dropped.
    localparam logic [1:0] ROW_NONE = 2'd3;

    // Multiplier operand sources.
    localparam logic [1:0] MSRC_CROSS = 2'd0;
    localparam logic [1:0] MSRC_DET   = 2'd1;
    localparam logic [1:0] MSRC_SOLVE = 2'd2;

    // Divider numerator sources.
    localparam logic DSRC_ADJ = 1'b0;
    localparam logic DSRC_ACC = 1'b1;

    // Pair of matrix store addresses for one product.
    typedef struct packed {
        logic [3:0] a;
        logic [3:0] b;
    } t_mat_pair;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       in_load;
        logic       mem_we;
        logic [3:0] mem_wa;
        logic [1:0] mem_col;
        logic [3:0] mat_ra;
        logic [3:0] mat_rb;
        logic [3:0] adj_ra;
        logic       mul_load;
        logic [1:0] mul_src;
        logic [1:0] vsel;
        logic       acc_clr;
        logic       mul_neg;
        logic       mul_step;
        logic       mul_top;
        logic       adj_we;
        logic [3:0] adj_wa;
        logic       det_we;
        logic       div_load;
        logic       div_src;
        logic       div_step;
        logic       div_first;
        logic       res_we;
        logic [1:0] res_idx;
        logic       res_zero;
        logic       out_load;
        logic       out_det;
        logic [1:0] out_row;
        logic       out_sing;
        logic       out_last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic det_zero;
        logic can_push;
    } t_dp_status;

    // Next index modulo three.
    function automatic logic [1:0] nxt3(input logic [1:0] v);
        logic [1:0] r;
        case (v)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // Row-major address of element (row, col).
    function automatic logic [3:0] mat_addr(input logic [1:0] row, input logic [1:0] col);
        logic [3:0] r4;
        r4 = {2'b00, row};
        return (r4 << 1) + r4 + {2'b00, col};
    endfunction

    // Operand addresses of one term of cofactor (i, j). Column j selects the row pair
    // (j+1, j+2); component i takes elements (i+1, i+2). Term 1 is subtracted.
    function automatic t_mat_pair adj_term(input logic [1:0] i, input logic [1:0] j,
                                           input logic t);
        logic [1:0] p;
        logic [1:0] q;
        logic [1:0] e1;
        logic [1:0] e2;
        t_mat_pair  r;
        p  = nxt3(j);
        q  = nxt3(p);
        e1 = nxt3(i);
        e2 = nxt3(e1);
        r.a = t ? mat_addr(p, e2) : mat_addr(p, e1);
        r.b = t ? mat_addr(q, e1) : mat_addr(q, e2);
        return r;
    endfunction

endpackage

// ===== rtl/core/m3inv_ctrl.sv =====
// Sequencer of the 3x3 matrix inverse and solve block: handshake on the input side
// and the command stream to the datapath. Depends on m3inv_pkg.
module m3inv_ctrl
    import m3inv_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_mode,
    input  logic [1:0] i_row_select,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam int NDIG = (DATA_WIDTH + 7) / 8;
    localparam int CNTW = $clog2(DATA_WIDTH + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_LOAD   = 4'd1;
    localparam logic [3:0] ST_RD     = 4'd2;
    localparam logic [3:0] ST_LD     = 4'd3;
    localparam logic [3:0] ST_MUL    = 4'd4;
    localparam logic [3:0] ST_WB     = 4'd5;
    localparam logic [3:0] ST_DECIDE = 4'd6;
    localparam logic [3:0] ST_DRD    = 4'd7;
    localparam logic [3:0] ST_DLD    = 4'd8;
    localparam logic [3:0] ST_DIV    = 4'd9;
    localparam logic [3:0] ST_RES    = 4'd10;
    localparam logic [3:0] ST_PUSH   = 4'd11;

    localparam logic [1:0] PH_CROSS = 2'd0;
    localparam logic [1:0] PH_DET   = 2'd1;
    localparam logic [1:0] PH_SNUM  = 2'd2;

    logic [3:0]      r_state, n_state;
    logic [1:0]      r_ph, n_ph;
    logic [1:0]      r_mode, n_mode;
    logic [1:0]      r_row, n_row;
    logic [1:0]      r_i, n_i;
    logic [1:0]      r_j, n_j;
    logic [1:0]      r_t, n_t;
    logic [CNTW-1:0] r_cnt, n_cnt;
    t_mat_pair       pr;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_mode  = r_mode;
        n_row   = r_row;
        n_i     = r_i;
        n_j     = r_j;
        n_t     = r_t;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_stall = (r_state != ST_IDLE);
        pr      = adj_term(r_i, r_j, r_t[0]);

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_mode = i_mode;
                    n_row  = i_row_select;
                    n_i    = 2'd0;
                    n_j    = 2'd0;
                    n_t    = 2'd0;
                    n_ph   = PH_CROSS;
                    if (i_mode == MODE_LOAD) begin
                        if (i_row_select != ROW_NONE) n_state = ST_LOAD;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            // One matrix entry written per cycle.
            ST_LOAD: begin
                o_cmd.mem_we  = 1'b1;
                o_cmd.mem_wa  = mat_addr(r_row, r_j);
                o_cmd.mem_col = r_j;
                if (r_j == 2'd2) n_state = ST_IDLE;
                else n_j = r_j + 2'd1;
            end
            ST_RD: begin
                case (r_ph)
                    PH_CROSS: begin
                        o_cmd.mat_ra = pr.a;
                        o_cmd.mat_rb = pr.b;
                    end
                    PH_DET: begin
                        o_cmd.adj_ra = mat_addr(r_t, 2'd0);
                        o_cmd.mat_rb = mat_addr(2'd0, r_t);
                    end
                    default: begin
                        o_cmd.adj_ra = mat_addr(r_i, r_t);
                    end
                endcase
                n_state = ST_LD;
            end
            ST_LD: begin
                o_cmd.mul_load = 1'b1;
                o_cmd.acc_clr  = (r_t == 2'd0);
                o_cmd.mul_neg  = (r_ph == PH_CROSS) && r_t[0];
                o_cmd.vsel     = r_t;
                case (r_ph)
                    PH_CROSS: o_cmd.mul_src = MSRC_CROSS;
                    PH_DET:   o_cmd.mul_src = MSRC_DET;
                    default:  o_cmd.mul_src = MSRC_SOLVE;
                endcase
                n_cnt   = '0;
                n_state = ST_MUL;
            end
            // One eight-bit digit of the multiplier per cycle.
            ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                o_cmd.mul_top  = (r_cnt == CNTW'(NDIG - 1));
                if (r_cnt == CNTW'(NDIG - 1)) begin
                    if (((r_ph == PH_CROSS) && r_t[0]) || (r_t == 2'd2)) begin
                        n_state = ST_WB;
                    end else begin
                        n_t     = r_t + 2'd1;
                        n_state = ST_RD;
                    end
                end else begin
                    n_cnt = r_cnt + CNTW'(1);
                end
            end
            ST_WB: begin
                case (r_ph)
                    PH_CROSS: begin
                        o_cmd.adj_we = 1'b1;
                        o_cmd.adj_wa = mat_addr(r_i, r_j);
                        n_t = 2'd0;
                        if (r_j == 2'd2) begin
                            n_j = 2'd0;
                            if (r_i == 2'd2) begin
                                n_i  = 2'd0;
                                n_ph = PH_DET;
                            end else begin
                                n_i = r_i + 2'd1;
                            end
                        end else begin
                            n_j = r_j + 2'd1;
                        end
                        n_state = ST_RD;
                    end
                    PH_DET: begin
                        o_cmd.det_we = 1'b1;
                        n_state = ST_DECIDE;
                    end
                    default: begin
                        o_cmd.div_load = 1'b1;
                        o_cmd.div_src  = DSRC_ACC;
                        n_cnt   = '0;
                        n_state = ST_DIV;
                    end
                endcase
            end
            ST_DECIDE: begin
                n_i = 2'd0;
                n_j = 2'd0;
                n_t = 2'd0;
                if (r_mode == MODE_DET) begin
                    n_state = ST_PUSH;
                end else if (i_status.det_zero) begin
                    o_cmd.res_zero = 1'b1;
                    n_state = ST_PUSH;
                end else if (r_mode == MODE_INV) begin
                    n_state = ST_DRD;
                end else begin
                    n_ph    = PH_SNUM;
                    n_state = ST_RD;
                end
            end
            ST_DRD: begin
                o_cmd.adj_ra = mat_addr(r_i, r_j);
                n_state = ST_DLD;
            end
            ST_DLD: begin
                o_cmd.div_load = 1'b1;
                o_cmd.div_src  = DSRC_ADJ;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            // Overflow check, then one quotient bit per cycle.
            ST_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.div_first = (r_cnt == '0);
                if (r_cnt == CNTW'(DATA_WIDTH)) n_state = ST_RES;
                else n_cnt = r_cnt + CNTW'(1);
            end
            ST_RES: begin
                o_cmd.res_we = 1'b1;
                if (r_mode == MODE_INV) begin
                    o_cmd.res_idx = r_j;
                    if (r_j == 2'd2) begin
                        n_state = ST_PUSH;
                    end else begin
                        n_j     = r_j + 2'd1;
                        n_state = ST_DRD;
                    end
                end else begin
                    o_cmd.res_idx = r_i;
                    if (r_i == 2'd2) begin
                        n_state = ST_PUSH;
                    end else begin
                        n_i     = r_i + 2'd1;
                        n_t     = 2'd0;
                        n_state = ST_RD;
                    end
                end
            end
            // Hand a result word to the output register once it is free.
            ST_PUSH: begin
                if (i_status.can_push) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_det  = (r_mode == MODE_DET);
                    o_cmd.out_row  = (r_mode == MODE_INV) ? r_i : 2'd0;
                    o_cmd.out_sing = (r_mode != MODE_DET) && i_status.det_zero;
                    o_cmd.out_last = (r_mode != MODE_INV) || (r_i == 2'd2);
                    if ((r_mode == MODE_INV) && (r_i != 2'd2)) begin
                        n_i     = r_i + 2'd1;
                        n_j     = 2'd0;
                        n_state = i_status.det_zero ? ST_PUSH : ST_DRD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ph    <= PH_CROSS;
            r_mode  <= MODE_LOAD;
            r_row   <= 2'd0;
            r_i     <= 2'd0;
            r_j     <= 2'd0;
            r_t     <= 2'd0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_mode  <= n_mode;
            r_row   <= n_row;
            r_i     <= n_i;
            r_j     <= n_j;
            r_t     <= n_t;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== rtl/core/m3inv_dp.sv =====
// Datapath of the 3x3 matrix inverse and solve block: matrix and cofactor stores, digit
// serial multiply-accumulate, restoring divider, saturation and output register.
// Depends on m3inv_pkg; driven by m3inv_ctrl.
module m3inv_dp
    import m3inv_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    output t_dp_status                   o_status,
    input  logic signed [DATA_WIDTH-1:0] i_elem_a,
    input  logic signed [DATA_WIDTH-1:0] i_elem_b,
    input  logic signed [DATA_WIDTH-1:0] i_elem_c,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [1:0]                   o_out_row,
    output logic signed [DATA_WIDTH-1:0] o_out_a,
    output logic signed [DATA_WIDTH-1:0] o_out_b,
    output logic signed [DATA_WIDTH-1:0] o_out_c,
    output logic                         o_singular,
    output logic                         o_last
);

    localparam int NDIG = (DATA_WIDTH + 7) / 8;
    localparam int BW   = NDIG * 8;
    localparam int AW   = 2 * DATA_WIDTH + 1;
    localparam int DETW = 3 * DATA_WIDTH + 3;
    localparam int W    = 3 * DATA_WIDTH + 2 * FRAC_BITS + 4;
    localparam int DSW  = DETW + DATA_WIDTH;
    localparam int CW   = (W > DSW) ? W : DSW;

    // Saturate a magnitude with its sign to the signed data range.
    function automatic logic [DATA_WIDTH-1:0] sat_d(input logic neg, input logic ovf,
                                                    input logic [DATA_WIDTH-1:0] mag);
        logic [DATA_WIDTH-1:0] half;
        logic [DATA_WIDTH-1:0] r;
        half = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
        if (neg) begin
            r = (ovf || (mag > half)) ? half : -mag;
        end else begin
            r = (ovf || mag[DATA_WIDTH-1]) ? ~half : mag;
        end
        return r;
    endfunction

    logic signed [DATA_WIDTH-1:0] r_va, r_vb, r_vc;
    logic signed [DATA_WIDTH-1:0] wd;
    logic signed [DATA_WIDTH-1:0] v_sel;

    logic [DATA_WIDTH-1:0]        mat_mem [MAT_N];
    logic signed [DATA_WIDTH-1:0] r_mat_a, r_mat_b;
    logic [AW-1:0]                adj_mem [MAT_N];
    logic signed [AW-1:0]         r_adj_rd;

    logic signed [W-1:0]  opa;
    logic signed [BW-1:0] opb;
    logic signed [W-1:0]  r_mc;
    logic signed [BW-1:0] r_mp;
    logic signed [W-1:0]  r_acc;
    logic                 r_neg;
    logic signed [8:0]    dig9;
    logic signed [W+8:0]  prod;

    logic signed [DETW-1:0] r_det;
    logic [DETW-1:0]        det_mag;
    logic [DETW-1:0]        det_sh;
    logic                   det_ovf;
    logic [DATA_WIDTH-1:0]  det_sat;

    logic signed [W-1:0]   div_num;
    logic [W-1:0]          num_mag;
    logic [CW-1:0]         r_rem;
    logic [CW-1:0]         r_dsh;
    logic [DATA_WIDTH-1:0] r_q;
    logic                  r_ovf;
    logic                  r_qneg;
    logic                  ge;
    logic [DATA_WIDTH-1:0] q_sat;

    logic [DATA_WIDTH-1:0] r_res [3];
    logic                  r_out_valid;

    // Input word capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_va <= i_elem_a;
            r_vb <= i_elem_b;
            r_vc <= i_elem_c;
        end
    end

    // Column select for matrix writes and vector select for solve products.
    always_comb begin
        case (i_cmd.mem_col)
            2'd0:    wd = r_va;
            2'd1:    wd = r_vb;
            default: wd = r_vc;
        endcase
        case (i_cmd.vsel)
            2'd0:    v_sel = r_va;
            2'd1:    v_sel = r_vb;
            default: v_sel = r_vc;
        endcase
    end

    // Matrix store: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) mat_mem[i_cmd.mem_wa] <= wd;
        r_mat_a <= mat_mem[i_cmd.mat_ra];
        r_mat_b <= mat_mem[i_cmd.mat_rb];
    end

    // Cofactor store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.adj_we) adj_mem[i_cmd.adj_wa] <= r_acc[AW-1:0];
        r_adj_rd <= adj_mem[i_cmd.adj_ra];
    end

    // Multiplier operand selection.
    always_comb begin
        case (i_cmd.mul_src)
            MSRC_CROSS: begin
                opa = W'(r_mat_a);
                opb = BW'(r_mat_b);
            end
            MSRC_DET: begin
                opa = W'(r_adj_rd);
                opb = BW'(r_mat_b);
            end
            default: begin
                opa = W'(r_adj_rd);
                opb = BW'(v_sel);
            end
        endcase
    end

    // Low digits are unsigned; the top digit carries the sign.
    assign dig9 = i_cmd.mul_top ? {r_mp[7], r_mp[7:0]} : {1'b0, r_mp[7:0]};
    assign prod = r_mc * dig9;

    // Multiply-accumulate, one digit a cycle, wrapping modulo the accumulator width.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load) begin
            r_mc  <= opa;
            r_mp  <= opb;
            r_neg <= i_cmd.mul_neg;
            if (i_cmd.acc_clr) r_acc <= '0;
        end else if (i_cmd.mul_step) begin
            r_acc <= r_neg ? (r_acc - prod[W-1:0]) : (r_acc + prod[W-1:0]);
            r_mc  <= r_mc <<< 8;
            r_mp  <= r_mp >>> 8;
        end
    end

    // Determinant register and its scaled, saturated form.
    always_ff @(posedge i_clk) begin
        if (i_cmd.det_we) r_det <= r_acc[DETW-1:0];
    end

    assign det_mag = r_det[DETW-1] ? -r_det : r_det;
    assign det_sh  = det_mag >> (2 * FRAC_BITS);
    assign det_ovf = |det_sh[DETW-1:DATA_WIDTH];
    assign det_sat = sat_d(r_det[DETW-1], det_ovf, det_sh[DATA_WIDTH-1:0]);

    // Divider numerator: a cofactor scaled by two fraction widths, or a solve sum by one.
    assign div_num = (i_cmd.div_src == DSRC_ACC) ? (r_acc <<< FRAC_BITS)
                                                 : (W'(r_adj_rd) <<< (2 * FRAC_BITS));
    assign num_mag = div_num[W-1] ? -div_num : div_num;
    assign ge      = (r_rem >= r_dsh);

    // Restoring divider on magnitudes; the first step flags quotients too wide to hold.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem  <= CW'(num_mag);
            r_dsh  <= CW'(det_mag) << DATA_WIDTH;
            r_qneg <= div_num[W-1] ^ r_det[DETW-1];
            r_q    <= '0;
            r_ovf  <= 1'b0;
        end else if (i_cmd.div_step) begin
            if (i_cmd.div_first) begin
                r_ovf <= ge;
            end else begin
                if (ge) r_rem <= r_rem - r_dsh;
                r_q <= {r_q[DATA_WIDTH-2:0], ge};
            end
            r_dsh <= r_dsh >> 1;
        end
    end

    assign q_sat = sat_d(r_qneg, r_ovf, r_q);

    // Result row collected element by element.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_zero) begin
            r_res[0] <= '0;
            r_res[1] <= '0;
            r_res[2] <= '0;
        end else if (i_cmd.res_we) begin
            r_res[i_cmd.res_idx] <= q_sat;
        end
    end

    // Output register: holds a word until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_row  <= i_cmd.out_row;
            o_singular <= i_cmd.out_sing;
            o_last     <= i_cmd.out_last;
            if (i_cmd.out_det) begin
                o_out_a <= det_sat;
                o_out_b <= '0;
                o_out_c <= '0;
            end else begin
                o_out_a <= r_res[0];
                o_out_b <= r_res[1];
                o_out_c <= r_res[2];
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status.det_zero = (r_det == '0);
    assign o_status.can_push = !r_out_valid || !i_stall;

endmodule

// ===== rtl/core/matrix3x3_inverse_and_solve.sv =====
// 3x3 matrix determinant, inverse and linear solve in signed fixed point.
// Top level: joins m3inv_ctrl and m3inv_dp; depends on m3inv_pkg.
//
// Usage: an input word is taken when i_valid is high and o_stall is low. Mode 0 writes
// one matrix row (row select 3 is dropped) and gives no result. Mode 1 gives the
// determinant, mode 2 the three inverse rows, mode 3 the solution of M x = v for the
// vector in the word. A zero determinant in modes 2 and 3 gives zero values with the
// singular flag set. Results saturate to the signed data range. Result words leave
// through one output register: taken when o_valid is high and i_stall is low; o_last
// marks the final word of a request.
// Sequence: a row load writes the three entries of its row in turn. Every other mode
// first builds nine cofactors and the determinant on one digit-serial multiplier,
// 21 products in all. An inverse then takes nine quotients, a solve three elements
// of 3 products and one quotient each; each result word is registered on its way out.
// One word is worked on at a time; o_stall stays high until the last result is in the
// output register. While the receiver stalls, the sequencer waits with the next row.
// Reset empties the output register and returns the sequencer to idle; the matrix store
// is not cleared and must be loaded before use.
module matrix3x3_inverse_and_solve
    import m3inv_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_mode,
    input  logic [1:0]                   i_row_select,
    input  logic signed [DATA_WIDTH-1:0] i_elem_a,
    input  logic signed [DATA_WIDTH-1:0] i_elem_b,
    input  logic signed [DATA_WIDTH-1:0] i_elem_c,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_out_row,
    output logic signed [DATA_WIDTH-1:0] o_out_a,
    output logic signed [DATA_WIDTH-1:0] o_out_b,
    output logic signed [DATA_WIDTH-1:0] o_out_c,
    output logic                         o_singular,
    output logic                         o_last
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencer.
    m3inv_ctrl #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_row_select (i_row_select),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    // Arithmetic and storage.
    m3inv_dp #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_elem_a   (i_elem_a),
        .i_elem_b   (i_elem_b),
        .i_elem_c   (i_elem_c),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_out_row  (o_out_row),
        .o_out_a    (o_out_a),
        .o_out_b    (o_out_b),
        .o_out_c    (o_out_c),
        .o_singular (o_singular),
        .o_last     (o_last)
    );

endmodule

// ===== bench/matrix3x3_inverse_and_solve_chk.sv =====
// Result checker for the 3x3 matrix inverse and solve block.
// Watches the input and output channels, predicts results from accepted words and
// compares them. Depends on m3inv_pkg.
module matrix3x3_inverse_and_solve_chk
    import m3inv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_mode,
    input  logic [1:0]         i_row_select,
    input  logic signed [31:0] i_elem_a,
    input  logic signed [31:0] i_elem_b,
    input  logic signed [31:0] i_elem_c,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_out_row,
    input  logic signed [31:0] i_out_a,
    input  logic signed [31:0] i_out_b,
    input  logic signed [31:0] i_out_c,
    input  logic               i_singular,
    input  logic               i_last,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct packed {
        logic [1:0]  row;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic        sing;
        logic        last;
    } t_result;

    localparam int FB = FRAC_BITS_DEF;

    logic signed [31:0] mat_q [9];
    t_result            result_q [$];

    assign o_pending = result_q.size();

    // Clamp a wide value to the signed 32-bit range.
    function automatic logic [31:0] sat32(input logic signed [255:0] v);
        if (v > 256'sh7FFFFFFF) return 32'h7FFFFFFF;
        if (v < -256'sh80000000) return 32'h80000000;
        return v[31:0];
    endfunction

    // Signed division truncating toward zero.
    function automatic logic signed [255:0] div_tz(input logic signed [255:0] n,
                                                  input logic signed [255:0] d);
        logic [255:0] un;
        logic [255:0] ud;
        logic [255:0] q;
        un = n[255] ? -n : n;
        ud = d[255] ? -d : d;
        q  = un / ud;
        return (n[255] ^ d[255]) ? -$signed(q) : $signed(q);
    endfunction

    // Work out the expected words of one accepted request.
    task automatic predict_request(input logic [1:0] mode, input logic signed [31:0] va,
                                   input logic signed [31:0] vb,
                                   input logic signed [31:0] vc);
        logic signed [255:0] m [3][3];
        logic signed [255:0] adj [3][3];
        logic signed [255:0] det;
        logic signed [255:0] num;
        logic signed [255:0] vv [3];
        logic signed [255:0] mag;
        t_result r;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) m[i][j] = mat_q[i*3+j];
        // adj[i][j] is cofactor (j,i): component i of the cross product of row pair j.
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                adj[i][j] = m[(j+1)%3][(i+1)%3] * m[(j+2)%3][(i+2)%3]
                          - m[(j+1)%3][(i+2)%3] * m[(j+2)%3][(i+1)%3];
            end
        end
        det = m[0][0]*adj[0][0] + m[0][1]*adj[1][0] + m[0][2]*adj[2][0];
        vv[0] = va;
        vv[1] = vb;
        vv[2] = vc;
        case (mode)
            MODE_DET: begin
                mag = det[255] ? -det : det;
                mag = mag >>> (2*FB);
                r = '{2'd0, sat32(det[255] ? -mag : mag), 32'd0, 32'd0, 1'b0, 1'b1};
                result_q.push_back(r);
            end
            MODE_INV: begin
                for (int i = 0; i < 3; i++) begin
                    r = '{i[1:0], 32'd0, 32'd0, 32'd0, 1'b1, i == 2};
                    if (det != 0) begin
                        r.sing = 1'b0;
                        r.a = sat32(div_tz(adj[i][0] <<< (2*FB), det));
                        r.b = sat32(div_tz(adj[i][1] <<< (2*FB), det));
                        r.c = sat32(div_tz(adj[i][2] <<< (2*FB), det));
                    end
                    result_q.push_back(r);
                end
            end
            default: begin
                r = '{2'd0, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1};
                if (det != 0) begin
                    r.sing = 1'b0;
                    num = adj[0][0]*vv[0] + adj[0][1]*vv[1] + adj[0][2]*vv[2];
                    r.a = sat32(div_tz(num <<< FB, det));
                    num = adj[1][0]*vv[0] + adj[1][1]*vv[1] + adj[1][2]*vv[2];
                    r.b = sat32(div_tz(num <<< FB, det));
                    num = adj[2][0]*vv[0] + adj[2][1]*vv[1] + adj[2][2]*vv[2];
                    r.c = sat32(div_tz(num <<< FB, det));
                end
                result_q.push_back(r);
            end
        endcase
    endtask

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;

    // Input side: capture loads and predict requests.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !i_in_stall) begin
            if (i_mode == MODE_LOAD) begin
                if (i_row_select != ROW_NONE) begin
                    mat_q[i_row_select*3]   = i_elem_a;
                    mat_q[i_row_select*3+1] = i_elem_b;
                    mat_q[i_row_select*3+2] = i_elem_c;
                end
            end else begin
                predict_request(i_mode, i_elem_a, i_elem_b, i_elem_c);
            end
        end
    end

    // Output side: compare each accepted word with the oldest expectation.
    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (result_q.size() == 0) begin
                report_mismatch("unexpected word", i_out_a, 32'd0);
            end else begin
                w = result_q.pop_front();
                if (i_out_row !== w.row) report_mismatch("out_row", i_out_row, w.row);
                if (i_out_a !== w.a) report_mismatch("out_a", i_out_a, w.a);
                if (i_out_b !== w.b) report_mismatch("out_b", i_out_b, w.b);
                if (i_out_c !== w.c) report_mismatch("out_c", i_out_c, w.c);
                if (i_singular !== w.sing) report_mismatch("singular", i_singular, w.sing);
                if (i_last !== w.last) report_mismatch("last", i_last, w.last);
            end
        end
    end

endmodule

// ===== bench/matrix3x3_inverse_and_solve_tb.sv =====
// Stimulus and verdict for the 3x3 matrix inverse and solve block.
// Instantiates the block and matrix3x3_inverse_and_solve_chk; depends on m3inv_pkg.
module matrix3x3_inverse_and_solve_tb;
    import m3inv_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_mode;
    logic [1:0]         i_row_select;
    logic signed [31:0] i_elem_a;
    logic signed [31:0] i_elem_b;
    logic signed [31:0] i_elem_c;
    logic               o_valid;
    logic               i_stall;
    logic [1:0]         o_out_row;
    logic signed [31:0] o_out_a;
    logic signed [31:0] o_out_b;
    logic signed [31:0] o_out_c;
    logic               o_singular;
    logic               o_last;
    int                 error_count;
    int                 pending_words;
    logic               quiet_phase;
    logic               hold_receiver;

    matrix3x3_inverse_and_solve u_top (.*);

    matrix3x3_inverse_and_solve_chk u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_in_stall  (o_stall),
        .i_mode      (i_mode),
        .i_row_select(i_row_select),
        .i_elem_a    (i_elem_a),
        .i_elem_b    (i_elem_b),
        .i_elem_c    (i_elem_c),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out_row   (o_out_row),
        .i_out_a     (o_out_a),
        .i_out_b     (o_out_b),
        .i_out_c     (o_out_c),
        .i_singular  (o_singular),
        .i_last      (o_last),
        .o_errors    (error_count),
        .o_pending   (pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Random value, often an extreme or a small Q16.16 number.
    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2, 3: return $urandom_range(0, 8) * 32'sh10000 - 32'sh40000;
            4: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
            default: return $urandom;
        endcase
    endfunction

    // Offer one word and wait until it is taken; optional idle burst before it.
    task automatic send_word(input logic [1:0] mode, input logic [1:0] row,
                             input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c);
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_row_select <= row;
        i_elem_a     <= a;
        i_elem_b     <= b;
        i_elem_c     <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic load_matrix(input logic [31:0] m [9]);
        for (int r = 0; r < 3; r++)
            send_word(MODE_LOAD, r[1:0], m[r*3], m[r*3+1], m[r*3+2]);
    endtask

    // Receiver stall: random bursts, one long hold, none at the end.
    initial begin
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_receiver) begin
                i_stall <= 1'b1;
                repeat (600) @(posedge i_clk);
                i_stall <= 1'b0;
                wait (!hold_receiver);
            end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        #30000000;
        $display("matrix3x3_inverse_and_solve regression: fail");
        $finish;
    end

    // Main stimulus.
    initial begin
        logic [31:0] mat [9];
        int          waited;
        logic        drained;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_mode        = MODE_LOAD;
        i_row_select  = 2'd0;
        i_elem_a      = '0;
        i_elem_b      = '0;
        i_elem_c      = '0;
        quiet_phase   = 1'b0;
        hold_receiver = 1'b0;
        drained       = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: identity, then every request.
        mat = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
        load_matrix(mat);
        send_word(MODE_DET, 2'd0, 0, 0, 0);
        send_word(MODE_INV, 2'd0, 0, 0, 0);
        send_word(MODE_SOLVE, 2'd0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
        // Dropped load with row select three.
        send_word(MODE_LOAD, ROW_NONE, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F);
        send_word(MODE_DET, 2'd0, 0, 0, 0);
        // Singular matrix: two equal rows.
        mat = '{32'h20000, 32'h30000, 32'h10000, 32'h20000, 32'h30000, 32'h10000,
                32'h50000, 32'hFFFF0000, 32'h8000};
        load_matrix(mat);
        send_word(MODE_INV, 2'd0, 0, 0, 0);
        send_word(MODE_SOLVE, 2'd0, 32'h10000, 32'h20000, 32'h30000);
        // Extremes: the determinant and the solve saturate.
        mat = '{32'h7FFFFFFF, 32'h80000000, 0, 0, 32'h7FFFFFFF, 32'h80000000,
                32'h80000000, 0, 32'h7FFFFFFF};
        load_matrix(mat);
        send_word(MODE_DET, 2'd0, 0, 0, 0);
        send_word(MODE_INV, 2'd0, 0, 0, 0);
        send_word(MODE_SOLVE, 2'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        // Tiny determinant: inverse overflows.
        mat = '{1, 0, 0, 0, 1, 0, 0, 0, 32'hFFFFFFFF};
        load_matrix(mat);
        send_word(MODE_INV, 2'd0, 0, 0, 0);

        // Long receiver hold while requests keep coming.
        hold_receiver = 1'b1;
        send_word(MODE_DET, 2'd0, 0, 0, 0);
        send_word(MODE_INV, 2'd0, 0, 0, 0);
        send_word(MODE_SOLVE, 2'd0, 32'h10000, 0, 0);
        hold_receiver = 1'b0;

        // Random part: mostly full matrix then requests, some lone row loads.
        for (int n = 0; n < 385; ) begin
            if (n > 330) quiet_phase = 1'b1;
            if (n >= 200 && !drained) begin
                drained = 1'b1;
                i_valid <= 1'b0;
                wait (pending_words == 0);
                @(posedge i_clk);
            end
            if ($urandom_range(0, 3) != 0) begin
                for (int k = 0; k < 9; k++) mat[k] = rand_elem();
                if ($urandom_range(0, 7) == 0) for (int k = 0; k < 3; k++) mat[3+k] = mat[k];
                load_matrix(mat);
                n += 3;
            end else begin
                send_word(MODE_LOAD, 2'($urandom_range(0, 3)), rand_elem(), rand_elem(),
                          rand_elem());
                n++;
            end
            repeat ($urandom_range(1, 3)) begin
                send_word(2'($urandom_range(1, 3)), 2'($urandom_range(0, 3)), rand_elem(),
                          rand_elem(), rand_elem());
                n++;
            end
        end
        i_valid <= 1'b0;

        waited = 0;
        while (pending_words != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (500) @(posedge i_clk);
        if (error_count == 0 && pending_words == 0) begin
            $display("matrix3x3_inverse_and_solve regression: pass");
        end else begin
            $display("matrix3x3_inverse_and_solve regression: fail");
        end
        $finish;
    end

endmodule
